[hw/rtl/qpt_pkg.sv]
// Shared widths and constants for the quaternion pose to transform unit.
package qpt_pkg;
    localparam int QuatW    = 16;
    localparam int ProdW    = 32;
    localparam int NumW     = 34;
    localparam int NormW    = 33;
    localparam int MagW     = 33;
    localparam int DendW    = 49;
    localparam int DvsW     = 34;
    localparam int QuoW     = 15;
    localparam int DivSteps = 15;
    localparam int RotW     = 16;
    localparam int PosW     = 32;
    localparam int NumRot   = 9;
    localparam int DivFirst = 4;
    localparam int NumStg   = DivFirst + DivSteps + 1;
    localparam logic [QuoW-1:0] OneQ14 = QuoW'(16384);
endpackage

[hw/rtl/qpt_div_lane.sv]
// Pipelined restoring divider lane, one quotient bit per stage.
module qpt_div_lane (
    input  logic                                  i_clk,
    input  logic [qpt_pkg::DivSteps-1:0]          i_adv,
    input  logic [qpt_pkg::DendW-1:0]             i_dend,
    input  logic [qpt_pkg::DvsW-1:0]              i_dvs,
    output logic [qpt_pkg::QuoW-1:0]              o_quo
);
    localparam int S  = qpt_pkg::DivSteps;
    localparam int DW = qpt_pkg::DendW;

    logic [DW-1:0]               r_rem [0:S-1];
    logic [qpt_pkg::DvsW-1:0]    r_dvs [0:S-1];
    logic [qpt_pkg::QuoW-1:0]    r_q   [0:S-1];
    logic [DW-1:0]               n_rem [0:S-1];
    logic [qpt_pkg::QuoW-1:0]    n_q   [0:S-1];

    always_comb begin
        logic [DW-1:0]            rem_in;
        logic [qpt_pkg::DvsW-1:0] dvs_in;
        logic [qpt_pkg::QuoW-1:0] q_in;
        logic [DW-1:0]            trial;
        for (int k = 0; k < S; k++) begin
            if (k == 0) begin
                rem_in = i_dend;
                dvs_in = i_dvs;
                q_in   = '0;
            end else begin
                rem_in = r_rem[k-1];
                dvs_in = r_dvs[k-1];
                q_in   = r_q[k-1];
            end
            trial = DW'({dvs_in, {(S-1){1'b0}}}) >> k;
            if (rem_in >= trial) begin
                n_rem[k] = rem_in - trial;
                n_q[k]   = {q_in[qpt_pkg::QuoW-2:0], 1'b1};
            end else begin
                n_rem[k] = rem_in;
                n_q[k]   = {q_in[qpt_pkg::QuoW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < S; k++) begin
            if (i_adv[k]) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                r_dvs[k] <= (k == 0) ? i_dvs : r_dvs[k-1];
            end
        end
    end

    assign o_quo = r_q[S-1];
endmodule

[hw/rtl/quaternion_pose_to_transform_unit.sv]
// Top level: normalize a quaternion pose and emit a rotation matrix and translation.
//  channel  | direction | handshake          | payload
//  pose in  | input     | i_valid / o_stall  | i_quat_x..w, i_trans_x..z
//  xform out| output    | o_valid / i_stall  | o_rot_00..22, o_pos_x..z
// One request enters per cycle while o_stall is low; stages are input, products,
// sums, dividend, 15 divider steps, output.
// The 15-step divider pipeline, one quotient bit per stage, sets the latency.
// Reset clears all stage valid bits; payload registers are not reset.
// A stall holds the output; empty stages upstream still fill.
module quaternion_pose_to_transform_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [31:0] i_trans_x,
    input  logic signed [31:0] i_trans_y,
    input  logic signed [31:0] i_trans_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_rot_00,
    output logic signed [15:0] o_rot_01,
    output logic signed [15:0] o_rot_02,
    output logic signed [15:0] o_rot_10,
    output logic signed [15:0] o_rot_11,
    output logic signed [15:0] o_rot_12,
    output logic signed [15:0] o_rot_20,
    output logic signed [15:0] o_rot_21,
    output logic signed [15:0] o_rot_22,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z
);
    localparam int L  = qpt_pkg::NumStg;
    localparam int DF = qpt_pkg::DivFirst;
    localparam int NR = qpt_pkg::NumRot;
    localparam int LO = L - 1;

    logic         r_v   [0:L-1];
    logic [L-1:0] adv;

    logic signed [qpt_pkg::QuatW-1:0] r_qx, r_qy, r_qz, r_qw;
    logic signed [qpt_pkg::ProdW-1:0] r_xx, r_yy, r_zz, r_ww;
    logic signed [qpt_pkg::ProdW-1:0] r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    logic signed [qpt_pkg::NumW-1:0]  r_num [0:NR-1];
    logic        [qpt_pkg::NormW-1:0] r_n;
    logic        [qpt_pkg::DendW-1:0] r_dend [0:NR-1];
    logic        [qpt_pkg::DvsW-1:0]  r_dvs;
    logic        [NR-1:0]             r_neg  [DF-1:LO-1];
    logic                             r_zero [DF-1:LO-1];
    logic        [qpt_pkg::PosW-1:0]  r_tx [0:LO], r_ty [0:LO], r_tz [0:LO];
    logic signed [qpt_pkg::RotW-1:0]  r_rot [0:NR-1];
    logic        [qpt_pkg::QuoW-1:0]  quo [0:NR-1];

    logic signed [qpt_pkg::NumW-1:0]  n_num [0:NR-1];
    logic        [qpt_pkg::DendW-1:0] n_dend [0:NR-1];
    logic        [NR-1:0]             n_neg;
    logic signed [qpt_pkg::RotW-1:0]  n_rot [0:NR-1];

    always_comb begin
        adv[L-1] = !r_v[L-1] || !i_stall;
        for (int k = L - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign o_stall = !adv[0];
    assign o_valid = r_v[L-1];

    function automatic logic signed [qpt_pkg::NumW-1:0] sx(
        input logic signed [qpt_pkg::ProdW-1:0] p
    );
        return {{(qpt_pkg::NumW - qpt_pkg::ProdW){p[qpt_pkg::ProdW-1]}}, p};
    endfunction

    always_comb begin
        n_num[0] = sx(r_xx) + sx(r_ww) - sx(r_yy) - sx(r_zz);
        n_num[1] = sx(r_xy) - sx(r_wz);
        n_num[2] = sx(r_xz) + sx(r_wy);
        n_num[3] = sx(r_xy) + sx(r_wz);
        n_num[4] = sx(r_ww) + sx(r_yy) - sx(r_xx) - sx(r_zz);
        n_num[5] = sx(r_yz) - sx(r_wx);
        n_num[6] = sx(r_xz) - sx(r_wy);
        n_num[7] = sx(r_yz) + sx(r_wx);
        n_num[8] = sx(r_ww) + sx(r_zz) - sx(r_xx) - sx(r_yy);
    end

    always_comb begin
        logic signed [qpt_pkg::NumW-1:0] a;
        logic [qpt_pkg::MagW-1:0]        mag;
        for (int i = 0; i < NR; i++) begin
            n_neg[i] = r_num[i][qpt_pkg::NumW-1];
            a        = n_neg[i] ? -r_num[i] : r_num[i];
            mag      = a[qpt_pkg::MagW-1:0];
            if (i % 4 == 0) begin
                n_dend[i] = {1'b0, mag, 15'b0} + qpt_pkg::DendW'(r_n);
            end else begin
                n_dend[i] = {mag, 16'b0} + qpt_pkg::DendW'(r_n);
            end
        end
    end

    always_comb begin
        logic [qpt_pkg::QuoW-1:0] qs;
        logic signed [qpt_pkg::RotW-1:0] val;
        for (int i = 0; i < NR; i++) begin
            qs  = (quo[i] > qpt_pkg::OneQ14) ? qpt_pkg::OneQ14 : quo[i];
            val = $signed({1'b0, qs});
            if (r_zero[LO-1]) begin
                n_rot[i] = (i % 4 == 0) ? $signed({1'b0, qpt_pkg::OneQ14}) : '0;
            end else begin
                n_rot[i] = r_neg[LO-1][i] ? -val : val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < L; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            for (int k = 0; k < L; k++) begin
                if (adv[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_qx     <= i_quat_x;
            r_qy     <= i_quat_y;
            r_qz     <= i_quat_z;
            r_qw     <= i_quat_w;
            r_tx[0]  <= i_trans_x;
            r_ty[0]  <= i_trans_y;
            r_tz[0]  <= i_trans_z;
        end
        if (adv[1]) begin
            r_xx <= r_qx * r_qx;
            r_yy <= r_qy * r_qy;
            r_zz <= r_qz * r_qz;
            r_ww <= r_qw * r_qw;
            r_xy <= r_qx * r_qy;
            r_xz <= r_qx * r_qz;
            r_yz <= r_qy * r_qz;
            r_wx <= r_qw * r_qx;
            r_wy <= r_qw * r_qy;
            r_wz <= r_qw * r_qz;
        end
        if (adv[2]) begin
            for (int i = 0; i < NR; i++) begin
                r_num[i] <= n_num[i];
            end
            r_n <= qpt_pkg::NormW'(r_xx) + qpt_pkg::NormW'(r_yy)
                 + qpt_pkg::NormW'(r_zz) + qpt_pkg::NormW'(r_ww);
        end
        if (adv[DF-1]) begin
            for (int i = 0; i < NR; i++) begin
                r_dend[i] <= n_dend[i];
            end
            r_dvs          <= {r_n, 1'b0};
            r_neg[DF-1]    <= n_neg;
            r_zero[DF-1]   <= (r_n == '0);
        end
        for (int k = DF; k < LO; k++) begin
            if (adv[k]) begin
                r_neg[k]  <= r_neg[k-1];
                r_zero[k] <= r_zero[k-1];
            end
        end
        for (int k = 1; k <= LO; k++) begin
            if (adv[k]) begin
                r_tx[k] <= r_tx[k-1];
                r_ty[k] <= r_ty[k-1];
                r_tz[k] <= r_tz[k-1];
            end
        end
        if (adv[LO]) begin
            for (int i = 0; i < NR; i++) begin
                r_rot[i] <= n_rot[i];
            end
        end
    end

    for (genvar g = 0; g < NR; g++) begin : g_lane
        qpt_div_lane u_lane (
            .i_clk  (i_clk),
            .i_adv  (adv[DF +: qpt_pkg::DivSteps]),
            .i_dend (r_dend[g]),
            .i_dvs  (r_dvs),
            .o_quo  (quo[g])
        );
    end

    assign o_rot_00 = r_rot[0];
    assign o_rot_01 = r_rot[1];
    assign o_rot_02 = r_rot[2];
    assign o_rot_10 = r_rot[3];
    assign o_rot_11 = r_rot[4];
    assign o_rot_12 = r_rot[5];
    assign o_rot_20 = r_rot[6];
    assign o_rot_21 = r_rot[7];
    assign o_rot_22 = r_rot[8];
    assign o_pos_x  = r_tx[LO];
    assign o_pos_y  = r_ty[LO];
    assign o_pos_z  = r_tz[LO];

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("output request dropped under stall");
    a_take_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v[0])
        else $error("accepted request not captured");
    a_diag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rot_00 <= 16'sd16384 && o_rot_00 >= -16'sd16384))
        else $error("rotation entry out of range");
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
endmodule
